// ----- hdl/dvpd_pkg.sv -----
// ----------------------------------------------------------------------------
// dvpd_pkg
// shared widths, constants and types of the dual valve proportional drive
// ----------------------------------------------------------------------------
package dvpd_pkg;

  localparam int BASE_TEMP    = 1800;
  localparam int BALANCE_STEP = 5;
  localparam int FULL_DRIVE   = 100;
  localparam int SAT_DRIVE    = FULL_DRIVE + 1;

  localparam int TEMP_W     = 15;
  localparam int SP_W       = 14;
  localparam int DB_W       = 11;
  localparam int PB_W       = 13;
  localparam int DRV_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam int MAG_W = 15;
  localparam int SC_W  = 14;
  localparam int DIV_W = 28;
  localparam int P_W   = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SP_ONE,
    CFG_SP_TWO,
    CFG_TEMP_DB,
    CFG_TEMP_PB,
    CFG_RET_MIN,
    CFG_RET_DB,
    CFG_RET_PB
  } cfg_idx_t;

  typedef struct packed {
    logic [SP_W-1:0] sp_one;
    logic [SP_W-1:0] sp_two;
    logic [DB_W-1:0] temp_db;
    logic [PB_W-1:0] temp_pb;
    logic [SP_W-1:0] ret_min;
    logic [DB_W-1:0] ret_db;
    logic [PB_W-1:0] ret_pb;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic neg_one;
    logic neg_two;
    logic neg_ret;
    logic prot;
    logic bal_on;
  } side_t;

endpackage

// ----- hdl/dvpd_front.sv -----
// ----------------------------------------------------------------------------
// dvpd_front
// error magnitudes, balance condition and scaling products, two stages
// ----------------------------------------------------------------------------
module dvpd_front import dvpd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [TEMP_W-1:0] temp_one,
  input  logic signed [TEMP_W-1:0] temp_two,
  input  logic signed [TEMP_W-1:0] return_temp,
  input  logic                     protect_on,
  input  cfg_t                     cfg,
  output side_t                    side,
  output logic [DIV_W-1:0]         num_one,
  output logic [DIV_W-1:0]         num_two,
  output logic [DIV_W-1:0]         num_ret,
  output logic [PB_W-1:0]          den_temp,
  output logic [PB_W-1:0]          den_ret,
  output logic [DIV_W-1:0]         prod_one,
  output logic [DIV_W-1:0]         prod_two,
  output logic [SC_W-1:0]          den_one,
  output logic [SC_W-1:0]          den_two
);

  logic signed [TEMP_W+1:0] err_one, err_two, err_ret;
  logic [TEMP_W+1:0]        abs_one, abs_two, abs_ret;
  logic [MAG_W-1:0]         mag_one_c, mag_two_c, mag_ret_c;
  logic [SP_W-1:0]          lim;
  logic [SP_W:0]            sp_sum;
  logic                     cond;

  side_t            s1_side;
  logic [MAG_W-1:0] s1_mag_one, s1_mag_two, s1_mag_ret;
  logic [SC_W-1:0]  s1_a_one, s1_a_two, s1_b_one, s1_b_two, s1_mid;

  function automatic logic [MAG_W-1:0] dead_mag(logic [TEMP_W+1:0] a, logic [DB_W-1:0] db);
    logic [TEMP_W+1:0] dbx;
    logic [TEMP_W+1:0] r;
    dbx = (TEMP_W+2)'(db);
    r   = (a > dbx) ? a - dbx : '0;
    return r[MAG_W-1:0];
  endfunction

  always_comb begin
    err_one = $signed({3'b000, cfg.sp_one}) - $signed({{2{temp_one[TEMP_W-1]}}, temp_one});
    err_two = $signed({3'b000, cfg.sp_two}) - $signed({{2{temp_two[TEMP_W-1]}}, temp_two});
    err_ret = $signed({{2{return_temp[TEMP_W-1]}}, return_temp})
            - $signed({3'b000, cfg.ret_min});
    abs_one = err_one[TEMP_W+1] ? unsigned'(-err_one) : unsigned'(err_one);
    abs_two = err_two[TEMP_W+1] ? unsigned'(-err_two) : unsigned'(err_two);
    abs_ret = err_ret[TEMP_W+1] ? unsigned'(-err_ret) : unsigned'(err_ret);
    mag_one_c = dead_mag(abs_one, cfg.temp_db);
    mag_two_c = dead_mag(abs_two, cfg.temp_db);
    mag_ret_c = dead_mag(abs_ret, cfg.ret_db);
    lim    = SP_W'(BASE_TEMP) + SP_W'({cfg.temp_db, 1'b0});
    sp_sum = {1'b0, cfg.sp_one} + {1'b0, cfg.sp_two};
    cond   = (cfg.sp_one > lim) && (cfg.sp_two > lim)
          && ($signed(temp_one) > $signed({1'b0, lim}))
          && ($signed(temp_two) > $signed({1'b0, lim}));
  end

  // stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_side.valid <= 1'b0;
    end else begin
      s1_side.valid <= in_valid;
    end
    s1_side.neg_one <= err_one[TEMP_W+1];
    s1_side.neg_two <= err_two[TEMP_W+1];
    s1_side.neg_ret <= err_ret[TEMP_W+1];
    s1_side.prot    <= protect_on;
    s1_side.bal_on  <= cond;
    s1_mag_one <= mag_one_c;
    s1_mag_two <= mag_two_c;
    s1_mag_ret <= mag_ret_c;
    if (cond) begin
      s1_a_one <= temp_one[SC_W-1:0] - SC_W'(BASE_TEMP);
      s1_a_two <= temp_two[SC_W-1:0] - SC_W'(BASE_TEMP);
      s1_b_one <= cfg.sp_one - SC_W'(BASE_TEMP);
      s1_b_two <= cfg.sp_two - SC_W'(BASE_TEMP);
      s1_mid   <= sp_sum[SP_W:1] - SC_W'(BASE_TEMP);
    end else begin
      s1_a_one <= '0;
      s1_a_two <= '0;
      s1_b_one <= SC_W'(1);
      s1_b_two <= SC_W'(1);
      s1_mid   <= '0;
    end
  end

  // stage two
  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else begin
      side.valid <= s1_side.valid;
    end
    side.neg_one <= s1_side.neg_one;
    side.neg_two <= s1_side.neg_two;
    side.neg_ret <= s1_side.neg_ret;
    side.prot    <= s1_side.prot;
    side.bal_on  <= s1_side.bal_on;
    num_one  <= DIV_W'(s1_mag_one) * DIV_W'(FULL_DRIVE);
    num_two  <= DIV_W'(s1_mag_two) * DIV_W'(FULL_DRIVE);
    num_ret  <= DIV_W'(s1_mag_ret) * DIV_W'(FULL_DRIVE);
    prod_one <= DIV_W'(s1_a_one) * DIV_W'(s1_mid);
    prod_two <= DIV_W'(s1_a_two) * DIV_W'(s1_mid);
    den_one  <= s1_b_one;
    den_two  <= s1_b_two;
    den_temp <= (cfg.temp_pb == '0) ? PB_W'(1) : cfg.temp_pb;
    den_ret  <= (cfg.ret_pb == '0) ? PB_W'(1) : cfg.ret_pb;
  end

endmodule

// ----- hdl/dvpd_div.sv -----
// ----------------------------------------------------------------------------
// dvpd_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module dvpd_div import dvpd_pkg::*; #(
  parameter int NUM_W = DIV_W,
  parameter int DEN_W = SC_W
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot
);

  logic [NUM_W-1:0] nq  [1:NUM_W];
  logic [DEN_W-1:0] rem [1:NUM_W];
  logic [DEN_W-1:0] dd  [1:NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0] src_nq;
    logic [DEN_W-1:0] src_rem;
    logic [DEN_W-1:0] src_d;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign src_nq  = num;
      assign src_rem = '0;
      assign src_d   = den;
    end else begin : g_next
      assign src_nq  = nq[k];
      assign src_rem = rem[k];
      assign src_d   = dd[k];
    end

    assign trial = {src_rem, src_nq[NUM_W-1]};
    assign diff  = trial - {1'b0, src_d};
    assign ge    = trial >= {1'b0, src_d};

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq[k+1]  <= {src_nq[NUM_W-2:0], ge};
      dd[k+1]  <= src_d;
    end
  end

  assign quot = nq[NUM_W];

endmodule

// ----- hdl/dvpd_back.sv -----
// ----------------------------------------------------------------------------
// dvpd_back
// signed drives, return cap, balancing with spill and final clamp
// ----------------------------------------------------------------------------
module dvpd_back import dvpd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  side_t                   side,
  input  logic [DIV_W-1:0]        q_one,
  input  logic [DIV_W-1:0]        q_two,
  input  logic [DIV_W-1:0]        q_ret,
  input  logic [DIV_W-1:0]        s_one,
  input  logic [DIV_W-1:0]        s_two,
  input  logic [DB_W-1:0]         temp_db,
  output logic                    done,
  output logic signed [DRV_W-1:0] drive_one,
  output logic signed [DRV_W-1:0] drive_two
);

  localparam logic signed [P_W-1:0] FULL_P = P_W'(FULL_DRIVE);
  localparam logic signed [P_W-1:0] STEP_P = P_W'(BALANCE_STEP);

  logic signed [P_W-1:0]   p_one, p_two, p_ret;
  logic signed [DIV_W:0]   diff, hbs;
  logic signed [P_W-1:0]   bal;
  logic signed [P_W-1:0]   c_one, c_two;

  logic                    a_valid, a_bal_on;
  logic signed [P_W-1:0]   a_one, a_two, a_bal;

  function automatic logic signed [P_W-1:0] sat_drive(logic [DIV_W-1:0] q, logic neg);
    logic [6:0] m;
    m = (q > DIV_W'(SAT_DRIVE)) ? 7'(SAT_DRIVE) : q[6:0];
    return neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
  endfunction

  function automatic logic signed [P_W-1:0] clamp(logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] r;
    r = v;
    if (v > FULL_P) r = FULL_P;
    if (v < -FULL_P) r = -FULL_P;
    return r;
  endfunction

  always_comb begin
    p_one = sat_drive(q_one, side.neg_one);
    p_two = sat_drive(q_two, side.neg_two);
    p_ret = sat_drive(q_ret, side.neg_ret);
    if (side.prot) begin
      if (p_ret < p_one) p_one = p_ret;
      if (p_ret < p_two) p_two = p_ret;
    end
    diff = $signed({1'b0, s_one}) - $signed({1'b0, s_two});
    hbs  = $signed({(DIV_W-DB_W+1)'(0), temp_db});
    if (diff < -hbs) begin
      bal = STEP_P;
    end else if (diff > hbs) begin
      bal = -STEP_P;
    end else begin
      bal = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= side.valid;
    end
    a_bal_on <= side.bal_on;
    a_one    <= p_one;
    a_two    <= p_two;
    a_bal    <= bal;
  end

  always_comb begin
    c_one = a_one;
    c_two = a_two;
    if (a_bal_on) begin
      c_one = clamp(a_one) + a_bal;
      c_two = clamp(a_two) - a_bal;
      // spill excess to the other circuit
      if (c_one > FULL_P) begin
        c_two = c_two + (c_one - FULL_P);
        c_one = FULL_P;
      end else if (c_one < -FULL_P) begin
        c_two = c_two + (c_one + FULL_P);
        c_one = -FULL_P;
      end
      if (c_two > FULL_P) begin
        c_one = c_one + (c_two - FULL_P);
        c_two = FULL_P;
      end else if (c_two < -FULL_P) begin
        c_one = c_one + (c_two + FULL_P);
        c_two = -FULL_P;
      end
    end
    c_one = clamp(c_one);
    c_two = clamp(c_two);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
    drive_one <= c_one[DRV_W-1:0];
    drive_two <= c_two[DRV_W-1:0];
  end

endmodule

// ----- hdl/dual_valve_proportional_drive_unit.sv -----
// ----------------------------------------------------------------------------
// dual_valve_proportional_drive_unit
// two-circuit proportional valve drive with dead band, return cap and balance
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  sample    start / busy           temp_one, temp_two, return_temp, protect_on
//  result    done (one cycle)       drive_one, drive_two
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  a sample is taken every cycle; busy stays low
//  from start to done a sample passes the front stages, the 28-stage dividers and the back registers
//  rst is synchronous and empties the pipeline; the config registers return to defaults
//  results cannot be held off, so nothing ever stalls
// ----------------------------------------------------------------------------
module dual_valve_proportional_drive_unit import dvpd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [TEMP_W-1:0]    temp_one,
  input  logic signed [TEMP_W-1:0]    temp_two,
  input  logic signed [TEMP_W-1:0]    return_temp,
  input  logic                        protect_on,
  output logic                        done,
  output logic signed [DRV_W-1:0]     drive_one,
  output logic signed [DRV_W-1:0]     drive_two,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int PIPE_LAT = DIV_W + 4;

  cfg_t             cfg;
  side_t            f_side;
  side_t            chain [DIV_W];
  logic [DIV_W-1:0] num_one, num_two, num_ret, prod_one, prod_two;
  logic [DIV_W-1:0] q_one, q_two, q_ret, s_one, s_two;
  logic [PB_W-1:0]  den_temp, den_ret;
  logic [SC_W-1:0]  den_one, den_two;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sp_one  <= SP_W'(3200);
      cfg.sp_two  <= SP_W'(3400);
      cfg.temp_db <= DB_W'(50);
      cfg.temp_pb <= PB_W'(100);
      cfg.ret_min <= SP_W'(5500);
      cfg.ret_db  <= DB_W'(200);
      cfg.ret_pb  <= PB_W'(200);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SP_ONE:  cfg.sp_one  <= cfg_data[SP_W-1:0];
        CFG_SP_TWO:  cfg.sp_two  <= cfg_data[SP_W-1:0];
        CFG_TEMP_DB: cfg.temp_db <= cfg_data[DB_W-1:0];
        CFG_TEMP_PB: cfg.temp_pb <= cfg_data[PB_W-1:0];
        CFG_RET_MIN: cfg.ret_min <= cfg_data[SP_W-1:0];
        CFG_RET_DB:  cfg.ret_db  <= cfg_data[DB_W-1:0];
        CFG_RET_PB:  cfg.ret_pb  <= cfg_data[PB_W-1:0];
        default: ;
      endcase
    end
  end

  dvpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .temp_one   (temp_one),
    .temp_two   (temp_two),
    .return_temp(return_temp),
    .protect_on (protect_on),
    .cfg        (cfg),
    .side       (f_side),
    .num_one    (num_one),
    .num_two    (num_two),
    .num_ret    (num_ret),
    .den_temp   (den_temp),
    .den_ret    (den_ret),
    .prod_one   (prod_one),
    .prod_two   (prod_two),
    .den_one    (den_one),
    .den_two    (den_two)
  );

  dvpd_div #(.NUM_W(DIV_W), .DEN_W(PB_W)) u_div_one (
    .clk(clk), .num(num_one), .den(den_temp), .quot(q_one)
  );
  dvpd_div #(.NUM_W(DIV_W), .DEN_W(PB_W)) u_div_two (
    .clk(clk), .num(num_two), .den(den_temp), .quot(q_two)
  );
  dvpd_div #(.NUM_W(DIV_W), .DEN_W(PB_W)) u_div_ret (
    .clk(clk), .num(num_ret), .den(den_ret), .quot(q_ret)
  );
  dvpd_div #(.NUM_W(DIV_W), .DEN_W(SC_W)) u_div_sc_one (
    .clk(clk), .num(prod_one), .den(den_one), .quot(s_one)
  );
  dvpd_div #(.NUM_W(DIV_W), .DEN_W(SC_W)) u_div_sc_two (
    .clk(clk), .num(prod_two), .den(den_two), .quot(s_two)
  );

  // sideband travelling alongside the dividers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_W; k++) begin
        chain[k] <= '0;
      end
    end else begin
      chain[0] <= f_side;
      for (int k = 1; k < DIV_W; k++) begin
        chain[k] <= chain[k-1];
      end
    end
  end

  dvpd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .side     (chain[DIV_W-1]),
    .q_one    (q_one),
    .q_two    (q_two),
    .q_ret    (q_ret),
    .s_one    (s_one),
    .s_two    (s_two),
    .temp_db  (cfg.temp_db),
    .done     (done),
    .drive_one(drive_one),
    .drive_two(drive_two)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##PIPE_LAT done)
    else $error("transaction result missing");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, PIPE_LAT))
    else $error("result without a transaction");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (drive_one <= 8'sd100) && (drive_one >= -8'sd100)
          && (drive_two <= 8'sd100) && (drive_two >= -8'sd100))
    else $error("drive out of range");

endmodule

// ----- tb/tb_dual_valve_proportional_drive_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_valve_proportional_drive_unit
// checks both valve drives of every sample against a local prediction
// ----------------------------------------------------------------------------
// samples go in through start / busy with random gaps (none in the last phase)
// and come back on done; a scoreboard works out the expected drives from its
// own copy of the registers and compares each result in order. the registers
// are rewritten between phases while the pipeline is empty, extremes included.
// ----------------------------------------------------------------------------
module tb_dual_valve_proportional_drive_unit;
  import dvpd_pkg::*;

  localparam int LATENCY   = 32;
  localparam int WDOG_LIMIT = 2000;

  typedef struct {
    logic signed [DRV_W-1:0] one;
    logic signed [DRV_W-1:0] two;
  } drives_t;

  class drive_scoreboard;
    longint sp1, sp2, tdb, tpb, rmin, rdb, rpb;
    drives_t pending[$];
    int errors;

    function new();
      sp1 = 3200; sp2 = 3400; tdb = 50; tpb = 100;
      rmin = 5500; rdb = 200; rpb = 200;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SP_ONE:  sp1  = val;
        CFG_SP_TWO:  sp2  = val;
        CFG_TEMP_DB: tdb  = val[DB_W-1:0];
        CFG_TEMP_PB: tpb  = val[PB_W-1:0];
        CFG_RET_MIN: rmin = val;
        CFG_RET_DB:  rdb  = val[DB_W-1:0];
        CFG_RET_PB:  rpb  = val[PB_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v < -FULL_DRIVE) return -FULL_DRIVE;
      if (v > FULL_DRIVE) return FULL_DRIVE;
      return v;
    endfunction

    function longint sgn(longint v);
      return v < 0 ? -1 : 1;
    endfunction

    function longint babs(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint band_drive(longint err, longint db, longint pb);
      longint m;
      m = babs(err) - db;
      if (pb <= 0) pb = 1;
      if (m < 0) m = 0;
      m = m * 100 / pb;
      return sgn(err) * m;
    endfunction

    function void note_sample(logic signed [TEMP_W-1:0] a, logic signed [TEMP_W-1:0] b,
                              logic signed [TEMP_W-1:0] r, logic prot);
      longint t1, t2, tr, p1, p2, lim, pr, mid, s1, s2, d, bal, ov;
      drives_t e;
      t1 = a; t2 = b; tr = r;
      p1 = band_drive(sp1 - t1, tdb, tpb);
      p2 = band_drive(sp2 - t2, tdb, tpb);
      lim = BASE_TEMP + 2 * tdb;
      if (prot) begin
        pr = band_drive(tr - rmin, rdb, rpb);
        if (pr < p1) p1 = pr;
        if (pr < p2) p2 = pr;
      end
      if (sp1 > lim && sp2 > lim && t1 > lim && t2 > lim) begin
        mid = (sp1 + sp2) / 2 - BASE_TEMP;
        s1 = (t1 - BASE_TEMP) * mid / (sp1 - BASE_TEMP);
        s2 = (t2 - BASE_TEMP) * mid / (sp2 - BASE_TEMP);
        d = s1 - s2;
        bal = (d < -tdb) ? BALANCE_STEP : (d > tdb) ? -BALANCE_STEP : 0;
        p1 = clip(p1) + bal;
        p2 = clip(p2) - bal;
        if (babs(p1) > FULL_DRIVE) begin
          ov = (babs(p1) - FULL_DRIVE) * sgn(p1);
          p1 -= ov; p2 += ov;
        end
        if (babs(p2) > FULL_DRIVE) begin
          ov = (babs(p2) - FULL_DRIVE) * sgn(p2);
          p2 -= ov; p1 += ov;
        end
      end
      e.one = DRV_W'(clip(p1));
      e.two = DRV_W'(clip(p2));
      pending.push_back(e);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic signed [DRV_W-1:0] one, logic signed [DRV_W-1:0] two);
      drives_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %0d %0d", one, two));
        return;
      end
      e = pending.pop_front();
      if (one !== e.one) report($sformatf("drive_one %0d exp %0d", one, e.one));
      if (two !== e.two) report($sformatf("drive_two %0d exp %0d", two, e.two));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [TEMP_W-1:0] temp_one = '0, temp_two = '0, return_temp = '0;
  logic protect_on = 0;
  logic done;
  logic signed [DRV_W-1:0] drive_one, drive_two;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  drive_scoreboard sb = new();
  int idle_cycles = 0;
  bit gaps_on = 1;

  dual_valve_proportional_drive_unit uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(drive_one, drive_two);
    if (!rst && ((start && !busy) || done || (cfg_valid && cfg_ready))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("dual_valve_proportional_drive_unit test failed");
      $finish;
    end
  end

  task send_sample(int a, int b, int r, bit p);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    temp_one <= TEMP_W'(a); temp_two <= TEMP_W'(b); return_temp <= TEMP_W'(r);
    protect_on <= p;
    do @(posedge clk); while (busy);
    sb.note_sample(TEMP_W'(a), TEMP_W'(b), TEMP_W'(r), p);
  endtask

  task stop_samples();
    start <= 0;
    @(posedge clk);
  endtask

  task drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task write_reg(cfg_idx_t idx, int val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, CFG_DATA_W'(val));
  endtask

  function int rand_temp();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 32767)) - 16384;
      1: return $urandom_range(1800, 6000);
      default: return int'($urandom_range(0, 20000)) - 5000;
    endcase
  endfunction

  task random_samples(int n);
    int x;
    for (int i = 0; i < n; i++) begin
      x = rand_temp();
      send_sample(x, $urandom_range(0, 3) == 0 ? x + int'($urandom_range(0, 400)) - 200
                  : rand_temp(), rand_temp(), 1'($urandom_range(0, 1)));
    end
  endtask

  task set_all(int s1, int s2, int tdb, int tpb, int rm, int rdb, int rpb);
    write_reg(CFG_SP_ONE, s1);
    write_reg(CFG_SP_TWO, s2);
    write_reg(CFG_TEMP_DB, tdb);
    write_reg(CFG_TEMP_PB, tpb);
    write_reg(CFG_RET_MIN, rm);
    write_reg(CFG_RET_DB, rdb);
    write_reg(CFG_RET_PB, rpb);
    cfg_valid <= 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, zero error, balancing, protection
    send_sample(-16384, -16384, -16384, 1);
    send_sample(16383, 16383, 16383, 1);
    send_sample(3200, 3400, 5500, 0);
    send_sample(3250, 3350, 5700, 1);
    send_sample(0, 0, 0, 0);
    send_sample(-1, -1, -1, 1);
    send_sample(3000, 3600, 6000, 0);
    send_sample(3600, 3000, 5000, 1);
    send_sample(1901, 1901, 5500, 0);
    send_sample(1900, 1950, 5800, 1);
    send_sample(15000, 2000, 15000, 0);
    send_sample(2000, 15000, -5000, 1);
    send_sample(-5000, 15000, 7000, 1);
    stop_samples();
    drain();

    // pause the sender until the pipeline is empty, then reconfigure
    set_all(0, 0, 0, 0, 0, 0, 0);
    send_sample(5, -5, 0, 1);
    send_sample(0, 0, 3, 1);
    random_samples(40);
    stop_samples();
    drain();

    set_all(16383, 16383, 2047, 8191, 16383, 2047, 8191);
    random_samples(40);
    stop_samples();
    drain();

    set_all(15000, 15000, 0, 1, 15000, 0, 1);
    random_samples(40);
    stop_samples();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_all($urandom_range(1900, 9000), $urandom_range(1900, 9000),
              $urandom_range(0, 300), $urandom_range(1, 600),
              $urandom_range(0, 15000), $urandom_range(0, 2000), $urandom_range(1, 5000));
      random_samples(45);
      stop_samples();
      drain();
    end

    gaps_on = 0;
    set_all(3200, 3400, 50, 100, 5500, 200, 200);
    random_samples(60);
    stop_samples();
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("dual_valve_proportional_drive_unit test passed");
    end else begin
      $display("dual_valve_proportional_drive_unit test failed");
    end
    $finish;
  end

endmodule
